/* sv/dxt_pkg.sv */
// shared types and constants for the dxt block texel decoder
package dxt_pkg;

	localparam int TexelsPerBlock = 16;
	localparam int TexelIdxW      = $clog2(TexelsPerBlock);
	localparam int QueueDepthDef  = 2;

	// one classified block as it sits in the queue
	typedef struct packed {
		logic [2:0][7:0] e0;          // expanded endpoint 0, index 2 = red
		logic [2:0][7:0] e1;          // expanded endpoint 1
		logic            four_mode;
		logic [31:0]     color_codes;
		logic [7:0]      a0;
		logic [7:0]      a1;
		logic            alpha8;      // a0 > a1, eight-step alpha table
		logic            dxt1;        // opaque alpha
		logic [47:0]     alpha_codes;
	} dxt_blk_t;

	// back end status toward the top level
	typedef struct packed {
		logic                 issue;
		logic                 pop;
		logic [TexelIdxW-1:0] idx;
	} dxt_back_stat_t;

endpackage

/* sv/dxt_block_texel_decoder.sv */
// top level of the dxt block texel decoder
// an accepted block's first texel passes the queue, stage 1 and the output register
// throughput: one texel per cycle from the back end sequencer while out_ready is high
// the block queue lets the front take new blocks while the back end is busy or stalled
// reset clears the queue, the back end pipeline valids and block_format (dxt5)
module dxt_block_texel_decoder #(
	parameter int QueueDepth = dxt_pkg::QueueDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        block_format,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] color_end0,
	input  logic [15:0] color_end1,
	input  logic [31:0] color_codes,
	input  logic [7:0]  alpha_end0,
	input  logic [7:0]  alpha_end1,
	input  logic [47:0] alpha_codes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  texel_col,
	output logic [1:0]  texel_row,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic        last_texel
);
	import dxt_pkg::*;

	localparam int CntW = $clog2(QueueDepth + 1);

	logic             q_full;
	logic             q_push;
	dxt_blk_t         q_push_blk;
	logic             q_head_valid;
	dxt_blk_t         q_head_blk;
	logic [CntW-1:0]  q_count;
	dxt_back_stat_t   back_stat;

	dxt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.block_format (block_format),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.color_end0   (color_end0),
		.color_end1   (color_end1),
		.color_codes  (color_codes),
		.alpha_end0   (alpha_end0),
		.alpha_end1   (alpha_end1),
		.alpha_codes  (alpha_codes),
		.q_full       (q_full),
		.push         (q_push),
		.push_blk     (q_push_blk)
	);

	dxt_queue #(
		.QueueDepth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_blk   (q_push_blk),
		.pop        (back_stat.pop),
		.head_valid (q_head_valid),
		.head_blk   (q_head_blk),
		.full       (q_full),
		.count      (q_count)
	);

	dxt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_blk   (q_head_blk),
		.stat       (back_stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.texel_col  (texel_col),
		.texel_row  (texel_row),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.alpha      (alpha),
		.last_texel (last_texel)
	);

	// queue occupancy never goes past its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CntW'(QueueDepth))
		else $error("block queue overflow");

	// an accepted block is in the queue on the next cycle
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (q_count != '0))
		else $error("accepted block missing from queue");

	// the back end releases a block only as it issues its sixteenth texel
	a_pop_at_last: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> (back_stat.issue && back_stat.idx == TexelIdxW'(TexelsPerBlock - 1)))
		else $error("block released early");

	// texel index restarts at zero after a block is released
	a_idx_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |=> (back_stat.idx == '0))
		else $error("texel index did not restart");

endmodule

/* sv/dxt_front.sv */
// front end: format register, endpoint expansion and block classification
module dxt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              block_format,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       color_end0,
	input  logic [15:0]       color_end1,
	input  logic [31:0]       color_codes,
	input  logic [7:0]        alpha_end0,
	input  logic [7:0]        alpha_end1,
	input  logic [47:0]       alpha_codes,
	input  logic              q_full,
	output logic              push,
	output dxt_pkg::dxt_blk_t push_blk
);
	import dxt_pkg::*;

	logic fmt_q;

	// v*255/31 = 8v + floor(7v/31), the fraction by reciprocal 265/2^13
	function automatic logic [7:0] expand5(input logic [4:0] v);
		logic [7:0]  t;
		logic [16:0] p;
		t = 8'(v) * 8'd7;
		p = 17'(t) * 17'd265;
		return {v, 3'b000} + 8'(p[15:13]);
	endfunction

	// v*255/63 = 4v + floor(v/21)
	function automatic logic [7:0] expand6(input logic [5:0] v);
		logic [1:0] q;
		if (v >= 6'd63) begin
			q = 2'd3;
		end else if (v >= 6'd42) begin
			q = 2'd2;
		end else if (v >= 6'd21) begin
			q = 2'd1;
		end else begin
			q = 2'd0;
		end
		return {v, 2'b00} + 8'(q);
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
		end else if (cfg_valid) begin
			fmt_q <= block_format;
		end
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_blk.e0[2]       = expand5(color_end0[15:11]);
		push_blk.e0[1]       = expand6(color_end0[10:5]);
		push_blk.e0[0]       = expand5(color_end0[4:0]);
		push_blk.e1[2]       = expand5(color_end1[15:11]);
		push_blk.e1[1]       = expand6(color_end1[10:5]);
		push_blk.e1[0]       = expand5(color_end1[4:0]);
		push_blk.four_mode   = color_end0 > color_end1;
		push_blk.color_codes = color_codes;
		push_blk.a0          = alpha_end0;
		push_blk.a1          = alpha_end1;
		push_blk.alpha8      = alpha_end0 > alpha_end1;
		push_blk.dxt1        = fmt_q;
		push_blk.alpha_codes = alpha_codes;
	end

endmodule

/* sv/dxt_queue.sv */
// short block queue between front and back end
module dxt_queue #(
	parameter int QueueDepth = dxt_pkg::QueueDepthDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  dxt_pkg::dxt_blk_t               push_blk,
	input  logic                            pop,
	output logic                            head_valid,
	output dxt_pkg::dxt_blk_t               head_blk,
	output logic                            full,
	output logic [$clog2(QueueDepth+1)-1:0] count
);
	import dxt_pkg::*;

	localparam int PtrW = $clog2(QueueDepth);
	localparam int CntW = $clog2(QueueDepth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

	dxt_blk_t            mem_q [QueueDepth];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CntW-1:0]     count_q;

	assign full       = count_q == FullCnt;
	assign head_valid = count_q != '0;
	assign head_blk   = mem_q[rd_ptr_q];
	assign count      = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/dxt_back.sv */
// back end: walks the sixteen texels of the head block, two stages to the output
module dxt_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  dxt_pkg::dxt_blk_t      head_blk,
	output dxt_pkg::dxt_back_stat_t stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             texel_col,
	output logic [1:0]             texel_row,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic [7:0]             alpha,
	output logic                   last_texel
);
	import dxt_pkg::*;

	typedef enum logic [2:0] {
		KIND_PASS,
		KIND_HALF,
		KIND_DIV3,
		KIND_DIV5,
		KIND_DIV7
	} div_kind_t;

	localparam logic [TexelIdxW-1:0] LastIdx = TexelIdxW'(TexelsPerBlock - 1);

	function automatic logic [7:0] div3(input logic [9:0] n);
		logic [19:0] p;
		p = 20'(n) * 20'd683;
		return p[18:11];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] n);
		logic [21:0] p;
		p = 22'(n) * 22'd1639;
		return p[20:13];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] n);
		logic [22:0] p;
		p = 23'(n) * 23'd2341;
		return p[21:14];
	endfunction

	function automatic logic [7:0] resolve(input div_kind_t kind, input logic [10:0] n);
		case (kind)
			KIND_PASS: return n[7:0];
			KIND_HALF: return n[8:1];
			KIND_DIV3: return div3(n[9:0]);
			KIND_DIV5: return div5(n);
			KIND_DIV7: return div7(n);
			default:   return n[7:0];
		endcase
	endfunction

	logic [TexelIdxW-1:0] idx_q;
	logic                 issue;
	logic                 s1_adv;

	logic                 valid_s1;
	logic [TexelIdxW-1:0] idx_s1;
	logic [2:0][9:0]      cnum_s1;
	div_kind_t            ckind_s1;
	logic [10:0]          anum_s1;
	div_kind_t            akind_s1;

	logic                 out_valid_q;
	logic [TexelIdxW-1:0] idx_out_q;
	logic [7:0]           red_q, green_q, blue_q, alpha_q;

	logic [1:0]           ccode;
	logic [2:0]           acode;
	logic [5:0]           abit;
	logic [2:0][9:0]      cnum;
	div_kind_t            ckind;
	logic [10:0]          anum;
	div_kind_t            akind;
	logic [3:0]           w0, w1;
	logic [11:0]          asum;

	assign s1_adv = valid_s1 && (!out_valid_q || out_ready);
	assign issue  = head_valid && (!valid_s1 || s1_adv);

	assign stat.issue = issue;
	assign stat.pop   = issue && (idx_q == LastIdx);
	assign stat.idx   = idx_q;

	assign ccode = head_blk.color_codes[{idx_q, 1'b0} +: 2];
	assign abit  = {1'b0, idx_q, 1'b0} + {2'b00, idx_q};
	assign acode = head_blk.alpha_codes[abit +: 3];

	// colour numerator and the division that finishes it
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cnum[k] = 10'(head_blk.e0[k]);
		end
		ckind = KIND_PASS;
		case (ccode)
			2'd0: begin
				for (int k = 0; k < 3; k++) cnum[k] = 10'(head_blk.e0[k]);
			end
			2'd1: begin
				for (int k = 0; k < 3; k++) cnum[k] = 10'(head_blk.e1[k]);
			end
			2'd2: begin
				if (head_blk.four_mode) begin
					for (int k = 0; k < 3; k++)
						cnum[k] = {1'b0, head_blk.e0[k], 1'b0} + 10'(head_blk.e1[k]);
					ckind = KIND_DIV3;
				end else begin
					for (int k = 0; k < 3; k++)
						cnum[k] = 10'(head_blk.e0[k]) + 10'(head_blk.e1[k]);
					ckind = KIND_HALF;
				end
			end
			default: begin
				if (head_blk.four_mode) begin
					for (int k = 0; k < 3; k++)
						cnum[k] = 10'(head_blk.e0[k]) + {1'b0, head_blk.e1[k], 1'b0};
					ckind = KIND_DIV3;
				end else begin
					// three-colour black
					for (int k = 0; k < 3; k++) cnum[k] = '0;
				end
			end
		endcase
	end

	// alpha numerator: an endpoint, a constant (0 or 255, also 255 for opaque dxt1) or a weighted sum of the endpoints
	always_comb begin
		if (head_blk.alpha8) begin
			w0 = 4'd8 - {1'b0, acode};
		end else begin
			w0 = 4'd6 - {1'b0, acode};
		end
		w1   = {1'b0, acode} - 4'd1;
		asum = 12'(w0) * 12'(head_blk.a0) + 12'(w1) * 12'(head_blk.a1);
		anum  = 11'(head_blk.a0);
		akind = KIND_PASS;
		if (head_blk.dxt1) begin
			anum = 11'd255;
		end else if (acode == 3'd0) begin
			anum = 11'(head_blk.a0);
		end else if (acode == 3'd1) begin
			anum = 11'(head_blk.a1);
		end else if (head_blk.alpha8) begin
			anum  = asum[10:0];
			akind = KIND_DIV7;
		end else if (acode == 3'd6) begin
			anum = '0;
		end else if (acode == 3'd7) begin
			anum = 11'd255;
		end else begin
			anum  = asum[10:0];
			akind = KIND_DIV5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1   <= idx_q;
			cnum_s1  <= cnum;
			ckind_s1 <= ckind;
			anum_s1  <= anum;
			akind_s1 <= akind;
		end
		if (s1_adv) begin
			idx_out_q <= idx_s1;
			red_q     <= resolve(ckind_s1, 11'(cnum_s1[2]));
			green_q   <= resolve(ckind_s1, 11'(cnum_s1[1]));
			blue_q    <= resolve(ckind_s1, 11'(cnum_s1[0]));
			alpha_q   <= resolve(akind_s1, anum_s1);
		end
	end

	assign out_valid  = out_valid_q;
	assign texel_col  = idx_out_q[1:0];
	assign texel_row  = idx_out_q[3:2];
	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign alpha      = alpha_q;
	assign last_texel = idx_out_q == LastIdx;

endmodule

/* verif/dxt_block_texel_decoder_test.sv */
// testbench for the dxt block texel decoder: predicts and checks every texel of every block
`timescale 1ns / 100ps

module dxt_block_texel_decoder_test;
	import dxt_pkg::*;

	typedef struct packed {
		logic [15:0] c0;
		logic [15:0] c1;
		logic [31:0] codes;
		logic [7:0]  a0;
		logic [7:0]  a1;
		logic [47:0] acodes;
	} block_t;

	typedef struct packed {
		logic [1:0] col;
		logic [1:0] row;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} texel_t;

	// keeps the decoded texels of accepted blocks until the block emits them
	class texel_ledger;
		texel_t expected_texels[$];
		bit     dxt1_mode;
		int     errors;

		function new();
			dxt1_mode = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return expected_texels.size();
		endfunction

		function int widen5(logic [4:0] v);
			return (int'(v) * 255) / 31;
		endfunction

		function int widen6(logic [5:0] v);
			return (int'(v) * 255) / 63;
		endfunction

		function int alpha_of(int code, int a0, int a1);
			if (code == 0) return a0;
			if (code == 1) return a1;
			if (a0 > a1) return ((8 - code) * a0 + (code - 1) * a1) / 7;
			if (code == 6) return 0;
			if (code == 7) return 255;
			return ((6 - code) * a0 + (code - 1) * a1) / 5;
		endfunction

		function void note_block(block_t b);
			int     e0[3];
			int     e1[3];
			int     rgb[3];
			int     code;
			bit     four;
			texel_t t;
			four = b.c0 > b.c1;
			e0[0] = widen5(b.c0[15:11]);
			e0[1] = widen6(b.c0[10:5]);
			e0[2] = widen5(b.c0[4:0]);
			e1[0] = widen5(b.c1[15:11]);
			e1[1] = widen6(b.c1[10:5]);
			e1[2] = widen5(b.c1[4:0]);
			for (int i = 0; i < TexelsPerBlock; i++) begin
				code = int'(b.codes[2*i +: 2]);
				for (int k = 0; k < 3; k++) begin
					if (code == 0) rgb[k] = e0[k];
					else if (code == 1) rgb[k] = e1[k];
					else if (four) rgb[k] = (code == 2) ? (2 * e0[k] + e1[k]) / 3
					                                    : (e0[k] + 2 * e1[k]) / 3;
					else rgb[k] = (code == 2) ? (e0[k] + e1[k]) / 2 : 0;
				end
				t.col   = 2'(i & 3);
				t.row   = 2'(i >> 2);
				t.red   = 8'(rgb[0]);
				t.green = 8'(rgb[1]);
				t.blue  = 8'(rgb[2]);
				t.alpha = dxt1_mode ? 8'd255
				        : 8'(alpha_of(int'(b.acodes[3*i +: 3]), int'(b.a0), int'(b.a1)));
				t.last  = (i == TexelsPerBlock - 1);
				expected_texels.push_back(t);
			end
		endfunction

		task report_mismatch(string what, int got, int want);
			errors++;
			$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		endtask

		task check_texel(texel_t got);
			texel_t want;
			if (expected_texels.size() == 0) begin
				report_mismatch("texel with no block pending", got.row * 4 + got.col, -1);
			end else begin
				want = expected_texels.pop_front();
				if (got.col != want.col) report_mismatch("texel_col", got.col, want.col);
				if (got.row != want.row) report_mismatch("texel_row", got.row, want.row);
				if (got.red != want.red) report_mismatch("red", got.red, want.red);
				if (got.green != want.green) report_mismatch("green", got.green, want.green);
				if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
				if (got.alpha != want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
				if (got.last != want.last) report_mismatch("last_texel", got.last, want.last);
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        block_format;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] color_end0;
	logic [15:0] color_end1;
	logic [31:0] color_codes;
	logic [7:0]  alpha_end0;
	logic [7:0]  alpha_end1;
	logic [47:0] alpha_codes;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  texel_col;
	logic [1:0]  texel_row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        last_texel;

	texel_ledger ledger = new();
	bit          rx_stall_en;
	bit          tx_gap_en;

	dxt_block_texel_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.block_format(block_format),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.color_end0  (color_end0),
		.color_end1  (color_end1),
		.color_codes (color_codes),
		.alpha_end0  (alpha_end0),
		.alpha_end1  (alpha_end1),
		.alpha_codes (alpha_codes),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.texel_col   (texel_col),
		.texel_row   (texel_row),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.last_texel  (last_texel)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function block_t mk_block(logic [15:0] c0, logic [15:0] c1, logic [31:0] codes,
	                          logic [7:0] a0, logic [7:0] a1, logic [47:0] acodes);
		block_t b;
		b.c0 = c0;
		b.c1 = c1;
		b.codes = codes;
		b.a0 = a0;
		b.a1 = a1;
		b.acodes = acodes;
		return b;
	endfunction

	function block_t rand_block();
		block_t b;
		int     r;
		r = $urandom_range(0, 9);
		b.c0 = 16'($urandom);
		b.c1 = 16'($urandom);
		b.codes = $urandom;
		b.a0 = 8'($urandom);
		b.a1 = 8'($urandom);
		b.acodes = {16'($urandom), 32'($urandom)};
		// steer some blocks onto the mode boundaries
		if (r == 0) b.c1 = b.c0;
		if (r == 1) b.c1 = b.c0 - 16'd1;
		if (r == 2) b.c0 = b.c1 - 16'd1;
		if (r == 3) b.a1 = b.a0;
		if (r == 4) b.a1 = b.a0 - 8'd1;
		return b;
	endfunction

	always @(posedge clk) begin : monitor
		texel_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) ledger.dxt1_mode = block_format;
			if (in_valid && in_ready)
				ledger.note_block(mk_block(color_end0, color_end1, color_codes,
				                           alpha_end0, alpha_end1, alpha_codes));
			if (out_valid && out_ready) begin
				got.col   = texel_col;
				got.row   = texel_row;
				got.red   = red;
				got.green = green;
				got.blue  = blue;
				got.alpha = alpha;
				got.last  = last_texel;
				ledger.check_texel(got);
			end
		end
	end

	// receiver stalls
	initial begin : rx_stalls
		int n;
		out_ready = 1'b1;
		forever begin
			repeat ($urandom_range(1, 24)) @(negedge clk);
			if (rx_stall_en) begin
				n = pick_gap();
				if (n > 0) begin
					out_ready = 1'b0;
					repeat (n) @(negedge clk);
					out_ready = 1'b1;
				end
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task send_block(block_t b);
		int n;
		color_end0  = b.c0;
		color_end1  = b.c1;
		color_codes = b.codes;
		alpha_end0  = b.a0;
		alpha_end1  = b.a1;
		alpha_codes = b.acodes;
		in_valid    = 1'b1;
		forever begin
			@(posedge clk);
			if (in_ready) break;
		end
		@(negedge clk);
		n = tx_gap_en ? pick_gap() : 0;
		if (n > 0) begin
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task drain_texels();
		in_valid = 1'b0;
		while (ledger.pending() > 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task write_format(logic v);
		drain_texels();
		block_format = v;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task send_random(int count);
		for (int i = 0; i < count; i++) send_block(rand_block());
	endtask

	initial begin : stimulus
		logic [47:0] ramp;
		ramp = 48'o7654321076543210;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		block_format = 1'b0;
		in_valid     = 1'b0;
		color_end0   = '0;
		color_end1   = '0;
		color_codes  = '0;
		alpha_end0   = '0;
		alpha_end1   = '0;
		alpha_codes  = '0;
		rx_stall_en  = 1'b1;
		tx_gap_en    = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_format(1'b0);
		send_block(mk_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'd255, 8'd0, ramp));
		send_block(mk_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'd0, 8'd255, ramp));
		send_block(mk_block(16'h1234, 16'h1234, 32'hE4E4E4E4, 8'd128, 8'd128, ramp));
		send_block(mk_block(16'hF800, 16'h07E0, 32'h1B1B1B1B, 8'd1, 8'd0, ramp));
		send_block(mk_block(16'h001F, 16'hF800, 32'hE4E4E4E4, 8'd200, 8'd10, ramp));
		send_block(mk_block(16'h8000, 16'h7FFF, 32'hFFFFFFFF, 8'd0, 8'd0, '1));
		send_block(mk_block(16'h0000, 16'h0000, 32'h0, 8'd0, 8'd0, '0));
		send_block(mk_block(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'd255, 8'd255, '1));
		send_block(mk_block(16'h0001, 16'h0000, 32'hAAAAAAAA, 8'd254, 8'd255,
		                    48'o6666666666666666));
		send_block(mk_block(16'h0000, 16'h0001, 32'hFFFFFFFF, 8'd255, 8'd254, ramp));
		send_block(mk_block(16'h07E0, 16'h001F, 32'h55555555, 8'd37, 8'd211, ramp));

		// opaque format ignores the alpha fields
		write_format(1'b1);
		send_block(mk_block(16'hFFFF, 16'h0000, 32'hE4E4E4E4, 8'd0, 8'd255, ramp));
		send_block(mk_block(16'h0000, 16'hFFFF, 32'hE4E4E4E4, 8'd255, 8'd0, ramp));
		send_block(mk_block(16'h1234, 16'h1234, 32'hE4E4E4E4, 8'd9, 8'd3, '1));
		send_block(mk_block(16'h0000, 16'h0001, 32'hFFFFFFFF, 8'd0, 8'd0, '0));
		send_block(mk_block(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'd255, 8'd255, '1));

		write_format(1'b0);
		send_random(35);
		drain_texels();
		send_random(35);

		write_format(1'b1);
		send_random(70);

		// back to back with no stalls on either side
		write_format(1'b0);
		rx_stall_en = 1'b0;
		tx_gap_en   = 1'b0;
		send_random(35);
		rx_stall_en = 1'b1;
		tx_gap_en   = 1'b1;
		send_random(35);

		drain_texels();
		repeat (20) @(negedge clk);
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
sv/dxt_pkg.sv
sv/dxt_front.sv
sv/dxt_queue.sv
sv/dxt_back.sv
sv/dxt_block_texel_decoder.sv
verif/dxt_block_texel_decoder_test.sv
